@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is held.
`define VGPB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define VGPB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/vgpb_pkg.sv @@
// ----------------------------------------------------------------------------
// vgpb_pkg
// Types and constants of the voxel placement and bounds block.
// ----------------------------------------------------------------------------
package vgpb_pkg;

  localparam int AXES       = 3;
  localparam int IN_W       = 32;
  localparam int GRID_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Z      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_INVALID = 3'd6;

  // Status codes
  localparam logic [1:0] STATUS_VALID  = 2'd0;
  localparam logic [1:0] STATUS_FORCED = 2'd1;
  localparam logic [1:0] STATUS_FAILED = 2'd2;

  typedef struct packed {
    logic signed [IN_W-1:0] local_x;
    logic signed [IN_W-1:0] local_y;
    logic signed [IN_W-1:0] local_z;
    logic [IN_W-1:0]        voxel_color;
    logic                   final_voxel;
  } in_item_t;

  typedef struct packed {
    logic signed [GRID_W-1:0] grid_x;
    logic signed [GRID_W-1:0] grid_y;
    logic signed [GRID_W-1:0] grid_z;
    logic [IN_W-1:0]          out_color;
    logic [1:0]               status;
    logic signed [GRID_W-1:0] min_x;
    logic signed [GRID_W-1:0] min_y;
    logic signed [GRID_W-1:0] min_z;
    logic signed [GRID_W-1:0] max_x;
    logic signed [GRID_W-1:0] max_y;
    logic signed [GRID_W-1:0] max_z;
    logic                     end_of_set;
  } out_item_t;

  // What one axis lane reports to the merge stage
  typedef struct packed {
    logic                     ok;
    logic signed [GRID_W-1:0] grid;
  } lane_res_t;

endpackage

@@ hw/rtl/vgpb_lane.sv @@
// ----------------------------------------------------------------------------
// vgpb_lane
// One axis: pivot-shifted fixed-point sum, range and fraction check, grid value.
// ----------------------------------------------------------------------------
module vgpb_lane
  import vgpb_pkg::*;
#(
  parameter int FRACTION_BITS = 8,
  parameter int COORD_WIDTH   = 32
) (
  input  logic signed [IN_W-1:0] target,
  input  logic signed [IN_W-1:0] origin,
  input  logic signed [IN_W-1:0] local_pos,
  output lane_res_t              res
);

  localparam int SUM_W = IN_W + FRACTION_BITS + 2;
  localparam int TOP_W = SUM_W - COORD_WIDTH + 1;

  logic signed [SUM_W-1:0] target_ext;
  logic signed [SUM_W-1:0] origin_ext;
  logic signed [SUM_W-1:0] local_ext;
  logic signed [SUM_W-1:0] sum;
  logic [TOP_W-1:0]        top_bits;
  logic                    range_ok;
  logic                    frac_ok;

  assign target_ext = {{(SUM_W-IN_W){target[IN_W-1]}}, target};
  assign origin_ext = {{(SUM_W-IN_W){origin[IN_W-1]}}, origin};
  assign local_ext  = {{(SUM_W-IN_W-FRACTION_BITS){local_pos[IN_W-1]}}, local_pos,
                       {FRACTION_BITS{1'b0}}};
  assign sum        = target_ext + local_ext - origin_ext;

  // In range when all bits from the coordinate sign bit up agree
  assign top_bits = sum[SUM_W-1:COORD_WIDTH-1];
  assign range_ok = (&top_bits) || (~|top_bits);
  assign frac_ok  = ~|sum[FRACTION_BITS-1:0];

  assign res.ok   = range_ok && frac_ok;
  assign res.grid = sum[FRACTION_BITS+GRID_W-1:FRACTION_BITS];

endmodule

@@ hw/rtl/vgpb_merge.sv @@
// ----------------------------------------------------------------------------
// vgpb_merge
// Combine the axis lanes: failure tracking, running bounds, result assembly.
// ----------------------------------------------------------------------------
module vgpb_merge
  import vgpb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  lane_res_t lane_res [AXES],
  input  logic [IN_W-1:0] color,
  input  logic      final_voxel,
  input  logic      force_invalid,
  output out_item_t result
);

  logic                     failed_r, failed_nxt;
  logic                     first_r, first_nxt;
  logic signed [GRID_W-1:0] low_r  [AXES];
  logic signed [GRID_W-1:0] high_r [AXES];
  logic signed [GRID_W-1:0] low_nxt  [AXES];
  logic signed [GRID_W-1:0] high_nxt [AXES];

  logic                     all_ok;
  logic                     failed_upd;
  logic                     first_upd;
  logic signed [GRID_W-1:0] pos      [AXES];
  logic signed [GRID_W-1:0] low_upd  [AXES];
  logic signed [GRID_W-1:0] high_upd [AXES];

  assign all_ok     = lane_res[0].ok && lane_res[1].ok && lane_res[2].ok;
  assign failed_upd = failed_r || !all_ok;

  always_comb begin
    first_upd = first_r;
    for (int a = 0; a < AXES; a++) begin
      pos[a]      = all_ok ? lane_res[a].grid : '0;
      low_upd[a]  = low_r[a];
      high_upd[a] = high_r[a];
      // Freeze bounds once the set has failed
      if (all_ok && !failed_r) begin
        if (first_r || (pos[a] < low_r[a])) begin
          low_upd[a] = pos[a];
        end
        if (first_r || (pos[a] > high_r[a])) begin
          high_upd[a] = pos[a];
        end
      end
    end
    if (all_ok && !failed_r) begin
      first_upd = 1'b0;
    end
  end

  always_comb begin
    result.grid_x     = pos[0];
    result.grid_y     = pos[1];
    result.grid_z     = pos[2];
    result.out_color  = color;
    result.status     = failed_upd ? STATUS_FAILED :
                        (force_invalid ? STATUS_FORCED : STATUS_VALID);
    result.min_x      = low_upd[0];
    result.min_y      = low_upd[1];
    result.min_z      = low_upd[2];
    result.max_x      = high_upd[0];
    result.max_y      = high_upd[1];
    result.max_z      = high_upd[2];
    result.end_of_set = final_voxel;
  end

  always_comb begin
    failed_nxt = failed_r;
    first_nxt  = first_r;
    for (int a = 0; a < AXES; a++) begin
      low_nxt[a]  = low_r[a];
      high_nxt[a] = high_r[a];
    end
    if (accept) begin
      // End of set: start the next set fresh
      if (final_voxel) begin
        failed_nxt = 1'b0;
        first_nxt  = 1'b1;
        for (int a = 0; a < AXES; a++) begin
          low_nxt[a]  = '0;
          high_nxt[a] = '0;
        end
      end else begin
        failed_nxt = failed_upd;
        first_nxt  = first_upd;
        for (int a = 0; a < AXES; a++) begin
          low_nxt[a]  = low_upd[a];
          high_nxt[a] = high_upd[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failed_r <= 1'b0;
      first_r  <= 1'b1;
      for (int a = 0; a < AXES; a++) begin
        low_r[a]  <= '0;
        high_r[a] <= '0;
      end
    end else begin
      failed_r <= failed_nxt;
      first_r  <= first_nxt;
      for (int a = 0; a < AXES; a++) begin
        low_r[a]  <= low_nxt[a];
        high_r[a] <= high_nxt[a];
      end
    end
  end

endmodule

@@ hw/rtl/voxel_grid_place_bounds.sv @@
// ----------------------------------------------------------------------------
// voxel_grid_place_bounds
// Place voxels on the world grid and track the bounds of each voxel set.
// ----------------------------------------------------------------------------
// Usage:
//   Write the pivots and force_invalid through the cfg_ port while idle.
//   Voxels enter on in_valid/in_stall, one item per accepting edge; each
//   produces one result item on out_valid/out_stall, in order.
//   Three axis lanes convert the voxel side by side; a merge stage combines
//   them, updates the running bounds and fills the output register.
//   An accepted item's result is written to the output register, or to
//   the skid entry while the output is held. Throughput: one item per
//   cycle while in_stall is low, set by the combinational lane adders and
//   the bounds compare in the merge stage. Stall: a two-entry output
//   (register plus skid entry) takes items after out_stall rises until
//   the skid entry is full, which raises in_stall. Stalled results hold.
//   Reset: pivots and force_invalid clear to zero, both entries empty, the
//   error status clears and the bounds return to zero.
//   Status 2 latches on any failed conversion until the last voxel of the
//   set (final_voxel) has passed.
// ----------------------------------------------------------------------------
module voxel_grid_place_bounds
  import vgpb_pkg::*;
#(
  parameter int FRACTION_BITS = 8,
  parameter int COORD_WIDTH   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item
);

  logic signed [IN_W-1:0] target_r [AXES];
  logic signed [IN_W-1:0] origin_r [AXES];
  logic                   force_invalid_r;

  logic signed [IN_W-1:0] local_pos [AXES];
  lane_res_t              lane_res  [AXES];
  out_item_t              result;
  logic                   accept;
  logic                   out_take;

  out_item_t out_r, out_nxt;
  out_item_t skid_r, skid_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        target_r[a] <= '0;
        origin_r[a] <= '0;
      end
      force_invalid_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_X:      target_r[0] <= cfg_wdata;
        REG_TARGET_Y:      target_r[1] <= cfg_wdata;
        REG_TARGET_Z:      target_r[2] <= cfg_wdata;
        REG_ORIGIN_X:      origin_r[0] <= cfg_wdata;
        REG_ORIGIN_Y:      origin_r[1] <= cfg_wdata;
        REG_ORIGIN_Z:      origin_r[2] <= cfg_wdata;
        REG_FORCE_INVALID: force_invalid_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign local_pos[0] = in_item.local_x;
  assign local_pos[1] = in_item.local_y;
  assign local_pos[2] = in_item.local_z;

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    vgpb_lane #(
      .FRACTION_BITS (FRACTION_BITS),
      .COORD_WIDTH   (COORD_WIDTH)
    ) u_lane (
      .target    (target_r[a]),
      .origin    (origin_r[a]),
      .local_pos (local_pos[a]),
      .res       (lane_res[a])
    );
  end

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  vgpb_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .lane_res      (lane_res),
    .color         (in_item.voxel_color),
    .final_voxel   (in_item.final_voxel),
    .force_invalid (force_invalid_r),
    .result        (result)
  );

  // Output register with skid entry
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (accept) begin
        out_nxt       = result;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      // Park the item while the output is held
      skid_nxt       = result;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

@@ hw/rtl/vgpb_checker.sv @@
// ----------------------------------------------------------------------------
// vgpb_checker
// Port-level checks of the voxel placement block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vgpb_checker
  import vgpb_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input out_item_t out_item,
  input logic      out_valid,
  input logic      out_stall
);

  `VGPB_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")
  `VGPB_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_item), "stalled result changed")
  `VGPB_ASSERT(a_stall_needs_out, in_stall |-> out_valid, "input stalled with empty output")
  `VGPB_ASSERT(a_bounds_order, out_valid |-> ($signed(out_item.min_x) <= $signed(out_item.max_x)) && ($signed(out_item.min_y) <= $signed(out_item.max_y)) && ($signed(out_item.min_z) <= $signed(out_item.max_z)), "minimum above maximum")
  `VGPB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "output not empty after reset")

endmodule

bind voxel_grid_place_bounds vgpb_checker u_vgpb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_item  (out_item),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
